// File: sv/b2h_pkg.sv
`timescale 1ns / 1ps
// Package for the binned 2D histogram: constants, mode codes and shared types.
// No dependencies.
package b2h_pkg;
  localparam int MaxColumnsDef = 64;
  localparam int MaxRowsDef    = 64;
  localparam int CountBitsDef  = 32;
  localparam int ValueBitsDef  = 32;

  localparam int ModeBits  = 3;
  localparam int IndexBits = 7;
  localparam int OutIdxBits = 6;

  typedef enum logic [ModeBits-1:0] {
    MODE_ADD    = 3'd0,
    MODE_SET    = 3'd1,
    MODE_XWALL  = 3'd2,
    MODE_YWALL  = 3'd3,
    MODE_READ   = 3'd4
  } mode_t;

  localparam logic [0:0] REG_COLUMNS = 1'b0;
  localparam logic [0:0] REG_ROWS    = 1'b1;

  // Word handed from the bin finder to the count memory.
  typedef struct packed {
    logic        add;       // increment the chosen bank
    logic        set;       // overwrite the chosen bank
    logic        read;      // read both banks
    logic        miss;      // bump the miss counter
    logic        hit;
    logic        perp;
    logic [15:0] col;
    logic [15:0] row;
    logic [63:0] wval;
  } b2h_op_t;
endpackage

// File: sv/b2h_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples, results and configuration.
// Depends on b2h_pkg.
interface b2h_in_if import b2h_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ModeBits-1:0]   mode;
  logic signed [31:0]    x_value;
  logic signed [31:0]    y_value;
  logic signed [1:0]     polarization;
  logic [31:0]           write_value;
  logic [IndexBits-1:0]  column_index;
  logic [IndexBits-1:0]  row_index;
  modport source (output valid, mode, x_value, y_value, polarization, write_value,
                  column_index, row_index, input ready);
  modport sink (input valid, mode, x_value, y_value, polarization, write_value,
                column_index, row_index, output ready);
endinterface

interface b2h_out_if import b2h_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [OutIdxBits-1:0] column_out;
  logic [OutIdxBits-1:0] row_out;
  logic [31:0]           count_parallel;
  logic [31:0]           count_perp;
  logic [31:0]           out_of_bounds_total;
  modport source (output valid, hit, column_out, row_out, count_parallel, count_perp,
                  out_of_bounds_total, input ready);
  modport sink (input valid, hit, column_out, row_out, count_parallel, count_perp,
                out_of_bounds_total, output ready);
endinterface

interface b2h_cfg_if ();
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [6:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/b2h_finder.sv
`timescale 1ns / 1ps
// Wall registers and parallel compare that locate a sample's bin.
// Depends on b2h_pkg.
module b2h_finder import b2h_pkg::*; #(
  parameter int MAX_COLUMNS = MaxColumnsDef,
  parameter int MAX_ROWS    = MaxRowsDef,
  parameter int VALUE_BITS  = ValueBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [ModeBits-1:0]   mode,
  input  logic [31:0]           x_value,
  input  logic [31:0]           y_value,
  input  logic [1:0]            polarization,
  input  logic [63:0]           wval,
  input  logic [IndexBits-1:0]  column_index,
  input  logic [IndexBits-1:0]  row_index,
  input  logic [7:0]            n_cols,
  input  logic [7:0]            n_rows,
  output b2h_op_t               op,
  output logic                  wall_hit
);
  localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

  // Walls are flip-flops: all of them are compared in parallel.
  logic signed [VW-1:0] x_walls [MAX_COLUMNS+1];
  logic signed [VW-1:0] y_walls [MAX_ROWS+1];

  logic signed [VW-1:0] xv, yv;
  logic [MAX_COLUMNS-1:0] xin;
  logic [MAX_ROWS-1:0]    yin;
  logic [15:0] c, r;
  logic cf, rf;

  assign xv = x_value[VW-1:0];
  assign yv = y_value[VW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= MAX_COLUMNS; i++) x_walls[i] <= '0;
      for (int i = 0; i <= MAX_ROWS; i++) y_walls[i] <= '0;
    end else if (start) begin
      if (mode == MODE_XWALL && 32'(column_index) <= MAX_COLUMNS)
        x_walls[column_index] <= xv;
      if (mode == MODE_YWALL && 32'(row_index) <= MAX_ROWS)
        y_walls[row_index] <= yv;
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_COLUMNS; i++)
      xin[i] = (x_walls[i] <= xv) && (xv < x_walls[i+1]) && (32'(i) < 32'(n_cols));
    for (int j = 0; j < MAX_ROWS; j++)
      yin[j] = (y_walls[j] <= yv) && (yv < y_walls[j+1]) && (32'(j) < 32'(n_rows));
    // Priority encode the lowest matching bin.
    c = '0; cf = 1'b0;
    for (int i = MAX_COLUMNS-1; i >= 0; i--)
      if (xin[i]) begin c = 16'(i); cf = 1'b1; end
    r = '0; rf = 1'b0;
    for (int j = MAX_ROWS-1; j >= 0; j--)
      if (yin[j]) begin r = 16'(j); rf = 1'b1; end
  end

  always_comb begin
    op = '0;
    op.wval = wval;
    op.perp = (polarization == 2'b01);
    wall_hit = 1'b0;
    unique case (mode)
      MODE_ADD, MODE_SET: begin
        if (cf && rf) begin
          op.hit = 1'b1; op.col = c; op.row = r;
          op.add = (mode == MODE_ADD);
          op.set = (mode == MODE_SET);
        end else begin
          op.miss = (mode == MODE_ADD);
        end
      end
      MODE_XWALL: wall_hit = (32'(column_index) <= MAX_COLUMNS);
      MODE_YWALL: wall_hit = (32'(row_index) <= MAX_ROWS);
      MODE_READ: begin
        if (8'(column_index) < n_cols && 8'(row_index) < n_rows) begin
          op.hit = 1'b1; op.read = 1'b1;
          op.col = 16'(column_index); op.row = 16'(row_index);
        end
      end
      default: ;
    endcase
  end
endmodule

// File: sv/b2h_counts.sv
`timescale 1ns / 1ps
// Two count memories with read-modify-write, saturation and a clearing pass.
// Depends on b2h_pkg.
module b2h_counts import b2h_pkg::*; #(
  parameter int MAX_COLUMNS = MaxColumnsDef,
  parameter int MAX_ROWS    = MaxRowsDef,
  parameter int COUNT_BITS  = CountBitsDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_en,    // phase 1: issue read
  input  logic                  wr_en,    // phase 2: write back
  input  b2h_op_t               op_rd,
  input  b2h_op_t               op_wr,
  output logic                  clearing,
  output logic [COUNT_BITS-1:0] par_after,
  output logic [COUNT_BITS-1:0] perp_after
);
  localparam int Depth = MAX_COLUMNS * MAX_ROWS;
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = (COUNT_BITS < 64) ? COUNT_BITS : 64;
  localparam logic [CW-1:0] CMax = '1;

  logic [CW-1:0] par_mem  [Depth];
  logic [CW-1:0] perp_mem [Depth];
  logic [CW-1:0] par_q, perp_q;
  logic [AW:0]   clr_addr;
  logic [AW-1:0] ra, wa;
  logic [CW-1:0] sat_w;

  assign ra = AW'(32'(op_rd.col) * MAX_ROWS + 32'(op_rd.row));
  assign wa = AW'(32'(op_wr.col) * MAX_ROWS + 32'(op_wr.row));
  assign clearing = (clr_addr < (AW+1)'(Depth));
  assign sat_w = (CW < 64 && op_wr.wval > 64'(CMax)) ? CMax : CW'(op_wr.wval);

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (clearing) clr_addr <= clr_addr + 1'b1;
  end

  always_comb begin
    par_after  = par_q;
    perp_after = perp_q;
    if (op_wr.add) begin
      if (op_wr.perp) perp_after = (perp_q == CMax) ? perp_q : perp_q + 1'b1;
      else            par_after  = (par_q == CMax) ? par_q : par_q + 1'b1;
    end else if (op_wr.set) begin
      if (op_wr.perp) perp_after = sat_w;
      else            par_after  = sat_w;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      par_mem[clr_addr[AW-1:0]]  <= '0;
      perp_mem[clr_addr[AW-1:0]] <= '0;
    end else if (wr_en && (op_wr.add || op_wr.set)) begin
      par_mem[wa]  <= par_after;
      perp_mem[wa] <= perp_after;
    end
    if (rd_en) begin
      par_q  <= par_mem[ra];
      perp_q <= perp_mem[ra];
    end
  end
endmodule

// File: sv/binned_2d_histogram.sv
`timescale 1ns / 1ps
// Binned 2D histogram: top level with handshakes, config and result register.
// Depends on b2h_pkg, b2h_if, b2h_finder and b2h_counts.
//
// Usage: samples and commands enter on the in channel (mode 0 add, 1 override
// bin, 2/3 write an x/y wall, 4 read a bin). Each word yields exactly one result
// word on the out channel with hit, bin, both bin counts and the miss total.
// The cfg channel writes columns_in_use (index 0) and rows_in_use (index 1); the
// user does so while the block is idle, which the block itself does not enforce.
// Flow: an accepted word moves through ST_READ (count memory read) and ST_WRITE
// (modify, write back and load the result register); out.valid rises at write-back.
// The input reopens the cycle after write-back, so a new item is taken only once
// the last is through; only one item is in the pipeline.
// Wall compares are done in parallel against registered walls.
// Reset: walls, miss counter and config return to defaults; a clearing pass
// zeroes both count memories (MAX_COLUMNS*MAX_ROWS entries each, 4096 by default),
// during which in.ready is low. Config writes are taken at any time.
// Stall: a result held in the output register does not close the input; one
// more item may be accepted, and it waits at write-back until the register is
// taken.
module binned_2d_histogram import b2h_pkg::*; #(
  parameter int MAX_COLUMNS = MaxColumnsDef,
  parameter int MAX_ROWS    = MaxRowsDef,
  parameter int COUNT_BITS  = CountBitsDef,
  parameter int VALUE_BITS  = ValueBitsDef
) (
  input logic      clk,
  input logic      rst,
  b2h_in_if.sink   in,
  b2h_out_if.source out,
  b2h_cfg_if.sink  cfg
);
  localparam int CW = (COUNT_BITS < 64) ? COUNT_BITS : 64;
  localparam logic [CW-1:0] CMax = '1;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_READ  = 3'b010,
    ST_WRITE = 3'b100
  } state_t;

  state_t state;
  logic [6:0] cols_reg, rows_reg;
  logic [7:0] n_cols, n_rows;
  b2h_op_t op_f, op_a, op_b;
  logic wall_hit, wall_hit_a;
  logic clearing;
  logic [CW-1:0] par_after, perp_after;
  logic [CW-1:0] miss;
  logic accept, finish;

  assign n_cols = (32'(cols_reg) > MAX_COLUMNS) ? 8'(MAX_COLUMNS) : 8'(cols_reg);
  assign n_rows = (32'(rows_reg) > MAX_ROWS) ? 8'(MAX_ROWS) : 8'(rows_reg);

  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_reg <= 7'd64;
      rows_reg <= 7'd64;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_COLUMNS: cols_reg <= cfg.data;
        REG_ROWS:    rows_reg <= cfg.data;
        default: ;
      endcase
    end
  end

  // The input opens whenever the pipeline is empty and no clearing pass runs; an item
  // that reaches write-back while the result register is still full waits there.
  assign in.ready = (state == ST_IDLE) && !clearing;
  assign accept = in.valid && in.ready;
  assign finish = (state == ST_WRITE) && (!out.valid || out.ready);

  b2h_finder #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS), .VALUE_BITS(VALUE_BITS))
    u_finder (
    .clk, .rst, .start(accept), .mode(in.mode), .x_value(in.x_value),
    .y_value(in.y_value), .polarization(in.polarization),
    .wval(64'(in.write_value)), .column_index(in.column_index),
    .row_index(in.row_index), .n_cols, .n_rows, .op(op_f), .wall_hit
  );

  b2h_counts #(.MAX_COLUMNS(MAX_COLUMNS), .MAX_ROWS(MAX_ROWS), .COUNT_BITS(COUNT_BITS))
    u_counts (
    .clk, .rst, .rd_en(state == ST_READ), .wr_en(finish), .op_rd(op_a),
    .op_wr(op_b), .clearing, .par_after, .perp_after
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else begin
      unique case (state)
        ST_IDLE:  if (accept) state <= ST_READ;
        ST_READ:  state <= ST_WRITE;
        ST_WRITE: if (finish) state <= ST_IDLE;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_a <= op_f;
      wall_hit_a <= wall_hit;
    end
    if (state == ST_READ) op_b <= op_a;
  end

  always_ff @(posedge clk) begin
    if (rst) miss <= '0;
    else if (finish && op_b.miss && miss != CMax) miss <= miss + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) out.valid <= 1'b0;
    else if (finish) out.valid <= 1'b1;
    else if (out.ready) out.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out.hit <= op_b.hit | wall_hit_a;
      out.column_out <= op_b.hit ? op_b.col[OutIdxBits-1:0] : '0;
      out.row_out <= op_b.hit ? op_b.row[OutIdxBits-1:0] : '0;
      out.count_parallel <= op_b.hit ? 32'(par_after) : '0;
      out.count_perp <= op_b.hit ? 32'(perp_after) : '0;
      out.out_of_bounds_total <=
        32'((op_b.miss && miss != CMax) ? miss + 1'b1 : miss);
    end
  end
endmodule

// File: sv/b2h_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the binned 2D histogram, bound to the top level.
// Depends on b2h_pkg.
module b2h_checker import b2h_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [5:0]  out_col,
  input logic [31:0] out_par,
  input logic [31:0] out_oob
);
  // A valid result word follows each accepted word.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |-> ##3 out_valid) else $error("result missing");
  // Only one word is in the pipeline: the input closes right after a word is taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("input taken while busy");
  // Misses report zero bin fields.
  a_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_hit |-> out_col == '0 && out_par == '0)
    else $error("miss with bin data");
  // The miss total never goes down once a result has been shown.
  a_oob: assert property (@(posedge clk) disable iff (rst)
    $past(out_valid) |-> out_oob >= $past(out_oob)) else $error("miss total dropped");
endmodule

bind binned_2d_histogram b2h_checker u_b2h_checker (
  .clk, .rst, .in_valid(in.valid), .in_ready(in.ready), .out_valid(out.valid),
  .out_ready(out.ready), .out_hit(out.hit), .out_col(out.column_out),
  .out_par(out.count_parallel), .out_oob(out.out_of_bounds_total)
);

// File: tb/tb_binned_2d_histogram.sv
`timescale 1ns / 1ps
// Self-checking testbench for binned_2d_histogram: a directed table, then random phases.
// A local bin-and-count model predicts every result word. Depends on b2h_pkg and b2h_if.
module tb_binned_2d_histogram;
  import b2h_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int NCOL = MaxColumnsDef;
  localparam int NROW = MaxRowsDef;
  localparam logic [31:0] COUNT_TOP = 32'hFFFF_FFFF;
  localparam logic signed [31:0] VMIN = 32'sh8000_0000;
  localparam logic signed [31:0] VMAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [1:0]  pol;
    logic [31:0]        wval;
    logic [6:0]         ci;
    logic [6:0]         ri;
  } sample_t;

  typedef struct packed {
    logic        hit;
    logic [5:0]  col;
    logic [5:0]  row;
    logic [31:0] cpar;
    logic [31:0] cperp;
    logic [31:0] oob;
  } bin_report_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    sample_t     item;
    logic        has_exp;
    bin_report_t exp;
    logic [0:0]  reg_idx;
    logic [6:0]  reg_val;
  } table_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  b2h_in_if  in_ch ();
  b2h_out_if out_ch ();
  b2h_cfg_if cfg_ch ();

  binned_2d_histogram dut (.clk(clk), .rst(rst), .in(in_ch), .out(out_ch), .cfg(cfg_ch));

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the block's walls, count banks and registers.
  logic signed [31:0] x_edges [0:NCOL];
  logic signed [31:0] y_edges [0:NROW];
  logic [31:0] par_bank  [0:NCOL*NROW-1];
  logic [31:0] perp_bank [0:NCOL*NROW-1];
  logic [31:0] miss_total;
  logic [6:0]  cols_reg, rows_reg;

  bin_report_t pending_reports [$];
  table_row_t  directed [$];
  int errors = 0;
  int send_pct = 0;
  int stall_pct = 0;
  int idle_cycles = 0;

  function automatic int find_edge_bin(input logic is_x, input int n, input logic signed [31:0] v);
    int i;
    logic signed [31:0] lo, hi;
    for (i = 0; i < n; i++) begin
      lo = is_x ? x_edges[i] : y_edges[i];
      hi = is_x ? x_edges[i+1] : y_edges[i+1];
      if (lo <= v && v < hi) return i;
    end
    return n;
  endfunction

  function automatic bin_report_t bin_and_count(input sample_t s);
    bin_report_t r;
    int nc, nr, c, rr, a;
    r = '0;
    nc = (cols_reg > NCOL) ? NCOL : int'(cols_reg);
    nr = (rows_reg > NROW) ? NROW : int'(rows_reg);
    if (s.mode == MODE_ADD || s.mode == MODE_SET) begin
      c = find_edge_bin(1'b1, nc, s.x);
      rr = find_edge_bin(1'b0, nr, s.y);
      if (c < nc && rr < nr) begin
        a = c * NROW + rr;
        if (s.mode == MODE_ADD) begin
          if (s.pol == 2'sd1) begin
            if (perp_bank[a] != COUNT_TOP) perp_bank[a] = perp_bank[a] + 1;
          end else if (par_bank[a] != COUNT_TOP) begin
            par_bank[a] = par_bank[a] + 1;
          end
        end else if (s.pol == 2'sd1) begin
          perp_bank[a] = s.wval;
        end else begin
          par_bank[a] = s.wval;
        end
        r.hit = 1'b1;
        r.col = c[5:0];
        r.row = rr[5:0];
        r.cpar = par_bank[a];
        r.cperp = perp_bank[a];
      end else if (s.mode == MODE_ADD && miss_total != COUNT_TOP) begin
        miss_total = miss_total + 1;
      end
    end else if (s.mode == MODE_XWALL) begin
      if (s.ci <= NCOL) begin
        x_edges[s.ci] = s.x;
        r.hit = 1'b1;
      end
    end else if (s.mode == MODE_YWALL) begin
      if (s.ri <= NROW) begin
        y_edges[s.ri] = s.y;
        r.hit = 1'b1;
      end
    end else if (s.mode == MODE_READ) begin
      if (s.ci < nc && s.ri < nr) begin
        a = s.ci * NROW + s.ri;
        r.hit = 1'b1;
        r.col = s.ci[5:0];
        r.row = s.ri[5:0];
        r.cpar = par_bank[a];
        r.cperp = perp_bank[a];
      end
    end
    r.oob = miss_total;
    return r;
  endfunction

  function automatic sample_t mk(input logic [2:0] m, input logic signed [31:0] x,
                                 input logic signed [31:0] y, input logic signed [1:0] p,
                                 input logic [31:0] w, input logic [6:0] ci,
                                 input logic [6:0] ri);
    sample_t s;
    s.mode = m; s.x = x; s.y = y; s.pol = p; s.wval = w; s.ci = ci; s.ri = ri;
    return s;
  endfunction

  function automatic void row_item(input sample_t s, input logic chk, input bin_report_t e);
    table_row_t t;
    t = '0;
    t.kind = ROW_ITEM; t.item = s; t.has_exp = chk; t.exp = e;
    directed.push_back(t);
  endfunction

  function automatic void row_cfg(input logic [0:0] idx, input logic [6:0] val);
    table_row_t t;
    t = '0;
    t.kind = ROW_CFG; t.reg_idx = idx; t.reg_val = val;
    directed.push_back(t);
  endfunction

  function automatic bin_report_t rep(input logic h, input logic [5:0] c, input logic [5:0] r,
                                      input logic [31:0] oob);
    bin_report_t e;
    e = '0;
    e.hit = h; e.col = c; e.row = r; e.oob = oob;
    return e;
  endfunction

  // Presents one word after an optional gap and waits for it to be taken.
  // Each cycle the sender stays idle with probability send_pct percent.
  task automatic send_word(input sample_t s, input logic chk, input bin_report_t e);
    bin_report_t p;
    while ($urandom_range(99) < send_pct) begin
      @(negedge clk) in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.mode <= s.mode;
    in_ch.x_value <= s.x;
    in_ch.y_value <= s.y;
    in_ch.polarization <= s.pol;
    in_ch.write_value <= s.wval;
    in_ch.column_index <= s.ci;
    in_ch.row_index <= s.ri;
    do @(posedge clk); while (!in_ch.ready);
    p = bin_and_count(s);
    pending_reports.push_back(chk ? e : p);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_COLUMNS) cols_reg = val;
    else rows_reg = val;
    @(negedge clk) cfg_ch.valid <= 1'b0;
  endtask

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result word with no expectation: hit %0d col %0d row %0d", $time,
                 out_ch.hit, out_ch.column_out, out_ch.row_out);
        errors++;
      end else begin
        bin_report_t e;
        e = pending_reports.pop_front();
        if (out_ch.hit !== e.hit) begin
          $display("%0t: hit expected %0d actual %0d", $time, e.hit, out_ch.hit);
          errors++;
        end
        if (out_ch.column_out !== e.col) begin
          $display("%0t: column_out expected %0d actual %0d", $time, e.col, out_ch.column_out);
          errors++;
        end
        if (out_ch.row_out !== e.row) begin
          $display("%0t: row_out expected %0d actual %0d", $time, e.row, out_ch.row_out);
          errors++;
        end
        if (out_ch.count_parallel !== e.cpar) begin
          $display("%0t: count_parallel expected %h actual %h", $time, e.cpar,
                   out_ch.count_parallel);
          errors++;
        end
        if (out_ch.count_perp !== e.cperp) begin
          $display("%0t: count_perp expected %h actual %h", $time, e.cperp, out_ch.count_perp);
          errors++;
        end
        if (out_ch.out_of_bounds_total !== e.oob) begin
          $display("%0t: out_of_bounds_total expected %h actual %h", $time, e.oob,
                   out_ch.out_of_bounds_total);
          errors++;
        end
      end
    end
  end

  // Counts cycles with no word moving on any channel; covers the clearing pass.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("binned_2d_histogram: mismatch");
        $finish;
      end
    end
  end

  // Picks a value inside bin k of a wall set, or a random value now and then.
  function automatic logic signed [31:0] pick_coord(input logic is_x, input int n);
    int k;
    logic signed [31:0] lo, hi;
    if (n == 0 || $urandom_range(7) == 0) return $urandom;
    k = $urandom_range(n - 1);
    lo = is_x ? x_edges[k] : y_edges[k];
    hi = is_x ? x_edges[k+1] : y_edges[k+1];
    if (hi <= lo) return lo;
    return lo + $urandom_range(int'(hi - lo - 1));
  endfunction

  task automatic random_phase(input int n_ops);
    int nc, nr, i, sel;
    logic signed [31:0] v;
    logic [6:0] setting [0:4];
    sample_t s;
    setting[0] = 7'd1; setting[1] = 7'd2; setting[2] = 7'd64; setting[3] = 7'd127;
    setting[4] = 7'($urandom_range(1, 64));
    write_reg(REG_COLUMNS, setting[$urandom_range(4)]);
    write_reg(REG_ROWS, setting[$urandom_range(4)]);
    nc = (cols_reg > NCOL) ? NCOL : int'(cols_reg);
    nr = (rows_reg > NROW) ? NROW : int'(rows_reg);
    // Ascending walls so that most samples land in a bin.
    v = $signed(32'($urandom_range(2000000))) - 1000000;
    for (i = 0; i <= nc; i++) begin
      send_word(mk(MODE_XWALL, v, $urandom, 2'($urandom), $urandom, 7'(i), 7'($urandom)),
                1'b0, '0);
      v = v + $urandom_range(1, 3000);
    end
    v = $signed(32'($urandom_range(2000000))) - 1000000;
    for (i = 0; i <= nr; i++) begin
      send_word(mk(MODE_YWALL, $urandom, v, 2'($urandom), $urandom, 7'($urandom), 7'(i)),
                1'b0, '0);
      v = v + $urandom_range(1, 3000);
    end
    for (i = 0; i < n_ops; i++) begin
      s = mk(MODE_ADD, pick_coord(1'b1, nc), pick_coord(1'b0, nr), 2'($urandom), $urandom,
             7'($urandom), 7'($urandom));
      sel = $urandom_range(99);
      if (sel < 60) begin
        s.mode = MODE_ADD;
      end else if (sel < 70) begin
        s.mode = MODE_SET;
        if ($urandom_range(1)) s.wval = COUNT_TOP - $urandom_range(2);
      end else if (sel < 85) begin
        s.mode = MODE_READ;
        if ($urandom_range(3) != 0) begin
          s.ci = 7'($urandom_range(nc - 1));
          s.ri = 7'($urandom_range(nr - 1));
        end
      end else if (sel < 90) begin
        s.mode = MODE_XWALL;
        s.x = $urandom;
      end else if (sel < 95) begin
        s.mode = MODE_YWALL;
        s.y = $urandom;
      end else begin
        s.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
      end
      send_word(s, 1'b0, '0);
    end
  endtask

  initial begin
    int i, p, q;
    table_row_t t;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_ADD;
    in_ch.x_value = '0;
    in_ch.y_value = '0;
    in_ch.polarization = '0;
    in_ch.write_value = '0;
    in_ch.column_index = '0;
    in_ch.row_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_COLUMNS;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    for (i = 0; i <= NCOL; i++) x_edges[i] = '0;
    for (i = 0; i <= NROW; i++) y_edges[i] = '0;
    for (i = 0; i < NCOL*NROW; i++) begin
      par_bank[i] = '0;
      perp_bank[i] = '0;
    end
    miss_total = '0;
    cols_reg = 7'd64;
    rows_reg = 7'd64;

    row_item(mk(MODE_READ, 0, 0, 0, 0, 7'd0, 7'd0), 1'b1, rep(1, 0, 0, 0));
    row_item(mk(MODE_READ, 0, 0, 0, 0, 7'd64, 7'd0), 1'b1, rep(0, 0, 0, 0));
    row_item(mk(MODE_SPARE_LO, VMAX, VMIN, 1, COUNT_TOP, 7'd127, 7'd127), 1'b1,
             rep(0, 0, 0, 0));
    row_item(mk(MODE_XWALL, VMAX, 0, 0, 0, 7'd65, 7'd0), 1'b1, rep(0, 0, 0, 0));
    row_cfg(REG_COLUMNS, 7'd1);
    row_cfg(REG_ROWS, 7'd1);
    row_item(mk(MODE_XWALL, VMIN, 0, 0, 0, 7'd0, 7'd0), 1'b1, rep(1, 0, 0, 0));
    row_item(mk(MODE_XWALL, VMAX, 0, 0, 0, 7'd1, 7'd0), 1'b1, rep(1, 0, 0, 0));
    row_item(mk(MODE_YWALL, 0, VMIN, 0, 0, 7'd0, 7'd0), 1'b1, rep(1, 0, 0, 0));
    row_item(mk(MODE_YWALL, 0, VMAX, 0, 0, 7'd0, 7'd1), 1'b1, rep(1, 0, 0, 0));
    row_item(mk(MODE_YWALL, 0, 0, 0, 0, 7'd0, 7'd64), 1'b1, rep(1, 0, 0, 0));
    row_item(mk(MODE_ADD, VMIN, VMIN, -2'sd1, 0, 0, 0), 1'b0, '0);
    row_item(mk(MODE_ADD, VMAX, 0, 0, 0, 0, 0), 1'b0, '0);
    row_item(mk(MODE_SET, 0, 0, 2'sd1, COUNT_TOP, 0, 0), 1'b0, '0);
    row_item(mk(MODE_ADD, 0, 0, 2'sd1, 0, 0, 0), 1'b0, '0);
    row_item(mk(MODE_ADD, 0, 0, -2'sd2, 0, 0, 0), 1'b0, '0);
    row_item(mk(MODE_ADD, 0, 0, 2'sd0, 0, 0, 0), 1'b0, '0);
    row_item(mk(MODE_SET, VMIN, 0, 2'sd0, 0, 0, 0), 1'b0, '0);
    row_item(mk(MODE_SPARE_HI, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    row_cfg(REG_COLUMNS, 7'd0);
    row_item(mk(MODE_ADD, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    row_item(mk(MODE_READ, 0, 0, 0, 0, 7'd0, 7'd0), 1'b1, rep(0, 0, 0, 2));
    row_cfg(REG_COLUMNS, 7'd127);
    row_cfg(REG_ROWS, 7'd127);
    row_item(mk(MODE_READ, 0, 0, 0, 0, 7'd63, 7'd63), 1'b1, rep(1, 63, 63, 2));
    row_item(mk(MODE_READ, 0, 0, 0, 0, 7'd0, 7'd64), 1'b1, rep(0, 0, 0, 2));
    row_item(mk(MODE_ADD, 0, 0, 0, 0, 0, 0), 1'b0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed[k]) begin
      t = directed[k];
      if (t.kind == ROW_CFG) write_reg(t.reg_idx, t.reg_val);
      else send_word(t.item, t.has_exp, t.exp);
    end

    for (p = 0; p < 4; p++) begin
      send_pct  = (p == 1) ? 50 : (p == 3) ? 32 : 0;
      stall_pct = (p == 2) ? 50 : (p == 3) ? 32 : 0;
      for (q = 0; q < 2; q++) random_phase(122);
    end

    @(negedge clk) in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("binned_2d_histogram: match");
    else $display("binned_2d_histogram: mismatch");
    $finish;
  end
endmodule
